// ===== rtl/hrvs_pkg.sv =====
// Shared types, constants and helpers for the HRV time-domain statistics block.
package hrvs_pkg;

  localparam int MAX_INTERVALS = 65536;
  localparam int IV_W    = 13;   // interval field width
  localparam int CNT_W   = 17;   // interval / above counters
  localparam int SUM_W   = 29;
  localparam int SQ_W    = 42;
  localparam int THR_W   = 10;
  localparam int DIV_W   = 64;   // dividend width of the serial divider
  localparam int DEN_W   = 17;
  localparam int ROOT_W  = 32;
  localparam int OUT_W   = 17;
  localparam int PNN_W   = 15;
  localparam int SQ_SPLIT = 21;  // square_sum split for the n * square_sum product

  localparam logic [THR_W-1:0] THR_RESET = 10'd50;
  localparam logic [14:0]      PNN_SCALE = 15'd25600;

  typedef struct packed {
    logic [IV_W-1:0] interval_ms;
    logic            carries_interval;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean_q4;
    logic [OUT_W-1:0] sdnn_q4;
    logic [OUT_W-1:0] rmssd_q4;
    logic [OUT_W-1:0] nn50_count;
    logic [PNN_W-1:0] pnn50_q8;
    logic [OUT_W-1:0] count_out;
    logic             overflow;
  } out_item_t;

  // Closed run, handed from the front end to the back end
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sumsq;
    logic [SQ_W-1:0]  diffsq;
    logic [CNT_W-1:0] above;
    logic             ovf;
  } run_snap_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL0   = 8'b0000_0010,
    ST_MUL1   = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_DIVEND = 8'b0001_0000,
    ST_SQRT   = 8'b0010_0000,
    ST_SQEND  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } back_state_t;

  typedef enum logic [2:0] {
    OP_MEAN = 3'd0,
    OP_VAR1 = 3'd1,
    OP_VAR2 = 3'd2,
    OP_RMS  = 3'd3,
    OP_PNN  = 3'd4
  } back_op_t;

  function automatic logic [OUT_W-1:0] sat17(input logic [DIV_W-1:0] v);
    sat17 = (v > DIV_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/hrvs_front.sv =====
// Front end: takes intervals, updates the running sums, closes a run on last.
module hrvs_front import hrvs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,
  input  logic             q_full,
  output logic             q_push,
  output run_snap_t        q_data
);

  logic [THR_W-1:0] thr;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sumsq;
  logic [IV_W-1:0]  prev;
  logic [SQ_W-1:0]  diffsq;
  logic [CNT_W-1:0] above;
  logic             ovf;

  logic             take, full_cap, has_prev;
  logic [IV_W-1:0]  x, d;
  logic [2*IV_W-1:0] xx, dd;
  run_snap_t        nxt;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign x        = in_data.interval_ms;
  assign full_cap = (count == CNT_W'(MAX_INTERVALS));
  assign has_prev = (count != '0);
  assign d        = (x >= prev) ? (x - prev) : (prev - x);
  assign xx       = x * x;
  assign dd       = d * d;

  // Run totals after this item's interval
  always_comb begin
    nxt.n      = count;
    nxt.sum    = sum;
    nxt.sumsq  = sumsq;
    nxt.diffsq = diffsq;
    nxt.above  = above;
    nxt.ovf    = ovf;
    if (in_data.carries_interval) begin
      if (full_cap) begin
        nxt.ovf = 1'b1;
      end else begin
        nxt.n     = count + 1'b1;
        nxt.sum   = sum + SUM_W'(x);
        nxt.sumsq = sumsq + SQ_W'(xx);
        if (has_prev) begin
          nxt.diffsq = diffsq + SQ_W'(dd);
          if (d > IV_W'(thr)) nxt.above = above + 1'b1;
        end
      end
    end
  end

  assign q_push = take && in_data.last;
  assign q_data = nxt;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // Accumulators; cleared when the run closes
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; sum <= '0; sumsq <= '0; prev <= '0;
      diffsq <= '0; above <= '0; ovf <= 1'b0;
    end else if (take) begin
      if (in_data.last) begin
        count <= '0; sum <= '0; sumsq <= '0; prev <= '0;
        diffsq <= '0; above <= '0; ovf <= 1'b0;
      end else begin
        count  <= nxt.n;
        sum    <= nxt.sum;
        sumsq  <= nxt.sumsq;
        diffsq <= nxt.diffsq;
        above  <= nxt.above;
        ovf    <= nxt.ovf;
        if (in_data.carries_interval && !full_cap) prev <= x;
      end
    end
  end

endmodule

// ===== rtl/hrvs_queue.sv =====
// Two-entry queue of closed runs between front and back ends.
module hrvs_queue import hrvs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  run_snap_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output run_snap_t pop_data
);

  run_snap_t  mem [2];
  logic       wptr, rptr;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; cnt <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/hrvs_back.sv =====
// Back end: serial divides and square roots that turn run totals into statistics.
module hrvs_back import hrvs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  run_snap_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  back_state_t state;
  back_op_t    op;
  run_snap_t   run;
  logic [58:0] a;
  logic [57:0] b;
  logic [37:0] alo;
  logic [37:0] ahi;
  logic [31:0] pnn_num;
  out_item_t   res;
  logic        load_out;

  // serial divider
  logic [DIV_W-1:0] dnum;
  logic [DEN_W-1:0] dden, drem;
  logic [5:0]       dcnt;
  logic [DEN_W:0]   rsh;
  logic             dge;

  // serial square root
  logic [DIV_W-1:0]  sv;
  logic [ROOT_W+1:0] srem, r4, trial;
  logic [ROOT_W-1:0] sroot;
  logic [4:0]        scnt;
  logic              sge;

  assign rsh      = {drem, dnum[DIV_W-1]};
  assign dge      = (rsh >= {1'b0, dden});
  assign r4       = {srem[ROOT_W-1:0], sv[DIV_W-1 -: 2]};
  assign trial    = {sroot, 2'b01};
  assign sge      = (r4 >= trial);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_MEAN;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            run   <= q_data;
            res   <= {{(3*OUT_W){1'b0}}, q_data.above, {PNN_W{1'b0}}, q_data.n, q_data.ovf};
            state <= (q_data.n == '0) ? ST_DONE : ST_MUL0;
          end
        end
        ST_MUL0: begin
          alo     <= run.n * run.sumsq[SQ_SPLIT-1:0];
          ahi     <= run.n * run.sumsq[SQ_W-1:SQ_SPLIT];
          b       <= run.sum * run.sum;
          pnn_num <= run.above * PNN_SCALE;
          state   <= ST_MUL1;
        end
        ST_MUL1: begin
          a <= 59'(alo) + {ahi, {SQ_SPLIT{1'b0}}};
          // mean = 16 * sum / n
          dnum <= DIV_W'({run.sum, 4'b0}); dden <= run.n; drem <= '0; dcnt <= '0;
          op <= OP_MEAN; state <= ST_DIV;
        end
        ST_DIV: begin
          drem <= dge ? DEN_W'(rsh - {1'b0, dden}) : DEN_W'(rsh);
          dnum <= {dnum[DIV_W-2:0], dge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd63) state <= ST_DIVEND;
        end
        ST_DIVEND: begin
          drem <= '0; dcnt <= '0;
          state <= ST_DIV;
          case (op)
            OP_MEAN: begin
              res.mean_q4 <= sat17(dnum);
              if (a > 59'(b)) begin
                dnum <= DIV_W'(a - 59'(b)); dden <= run.n; op <= OP_VAR1;
              end else if (run.n > 17'd1) begin
                dnum <= DIV_W'({run.diffsq, 8'b0}); dden <= run.n - 1'b1; op <= OP_RMS;
              end else begin
                dnum <= DIV_W'(pnn_num); dden <= run.n; op <= OP_PNN;
              end
            end
            OP_VAR1: begin
              dnum <= {dnum[DIV_W-9:0], 8'b0}; dden <= run.n; op <= OP_VAR2;
            end
            OP_VAR2, OP_RMS: begin
              sv <= dnum; srem <= '0; sroot <= '0; scnt <= '0;
              state <= ST_SQRT;
            end
            OP_PNN: begin
              res.pnn50_q8 <= (dnum > DIV_W'({PNN_W{1'b1}})) ? {PNN_W{1'b1}}
                                                               : dnum[PNN_W-1:0];
              state <= ST_DONE;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_SQRT: begin
          srem  <= sge ? (r4 - trial) : r4;
          sroot <= {sroot[ROOT_W-2:0], sge};
          sv    <= {sv[DIV_W-3:0], 2'b00};
          scnt  <= scnt + 1'b1;
          if (scnt == 5'd31) state <= ST_SQEND;
        end
        ST_SQEND: begin
          drem <= '0; dcnt <= '0;
          state <= ST_DIV;
          if (op == OP_RMS) begin
            res.rmssd_q4 <= sat17(DIV_W'(sroot));
            dnum <= DIV_W'(pnn_num); dden <= run.n; op <= OP_PNN;
          end else begin
            res.sdnn_q4 <= sat17(DIV_W'(sroot));
            if (run.n > 17'd1) begin
              dnum <= DIV_W'({run.diffsq, 8'b0}); dden <= run.n - 1'b1; op <= OP_RMS;
            end else begin
              dnum <= DIV_W'(pnn_num); dden <= run.n; op <= OP_PNN;
            end
          end
        end
        ST_DONE: begin
          // hand off to the output register once it is free
          if (load_out) begin
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hrv_time_domain_stats.sv =====
// Top level: HRV time-domain statistics (mean, SDNN, RMSSD, NN50, pNN50).
//
// Input channel (in_valid/in_ready/in_data): one NN interval per transfer;
// carries_interval marks a real interval, last closes the run. Intervals are
// folded into running sums in the cycle they are accepted, so the input takes
// one transfer per cycle while the run queue has room.
// Closing a run pushes its totals into a two-entry queue; the back end works
// on one closed run at a time with a 1-bit-per-cycle divider and a
// 2-bit-per-cycle square root. A non-empty run needs 2 to 5 divides and up
// to 2 roots before its result is valid; an empty run skips them all.
// Output channel (out_valid/out_ready/out_data): one result per run, held in
// an output register until taken. While the receiver stalls, the back end
// finishes the next run and waits; the input stalls only when both queue
// entries are occupied.
// cfg_wr_en/cfg_wr_data write the NN50 difference threshold (reset 50 ms).
// Reset (rst, synchronous) clears the run totals, the queue and the output.
module hrv_time_domain_stats import hrvs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data
);

  logic      q_full, q_push, q_pop, q_empty;
  run_snap_t q_in, q_out;

  hrvs_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .cfg_wr_en, .cfg_wr_data,
    .q_full, .q_push, .q_data(q_in)
  );

  hrvs_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  hrvs_back u_back (
    .clk, .rst, .q_empty, .q_data(q_out), .q_pop,
    .out_valid, .out_ready, .out_data
  );

endmodule
